### sv/ispf_pkg.sv
// Package for the sparse FIR input shaper: widths, register indexes, types.
// No dependencies; used by every other file of the block.
package ispf_pkg;

    // Ring depth, a power of two: addresses wrap by truncation
    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int MAX_TAPS   = 4;
    localparam int TIDX_W     = $clog2(MAX_TAPS);
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LAG_W      = 10;
    localparam int TAPCNT_W   = 3;
    localparam int FRAC_BITS  = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // sample times unsigned gain, as a signed product
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W      = PROD_W + TIDX_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT = 3'd0,
        REG_GAIN_TAP0 = 3'd1,
        REG_GAIN_TAP1 = 3'd2,
        REG_GAIN_TAP2 = 3'd3,
        REG_GAIN_TAP3 = 3'd4,
        REG_LAG_TAP1  = 3'd5,
        REG_LAG_TAP2  = 3'd6,
        REG_LAG_TAP3  = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic acc_clear;
        logic mul_en;
        logic acc_en;
    } mac_ctl_t;

endpackage

### sv/ispf_delay_ram.sv
// Delay line storage: one write port, one registered read port.
// Depends on ispf_pkg for depth and sample width.
module ispf_delay_ram
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [ispf_pkg::ADDR_W-1:0]         wr_addr,
    input  logic [ispf_pkg::SAMPLE_W-1:0]       wr_data,
    input  logic                                rd_en,
    input  logic [ispf_pkg::ADDR_W-1:0]         rd_addr,
    output logic [ispf_pkg::SAMPLE_W-1:0]       rd_data
);

    logic [ispf_pkg::SAMPLE_W-1:0] mem [ispf_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/ispf_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation.
// Depends on ispf_pkg for widths and the mac_ctl_t control group.
module ispf_mac
(
    input  logic                                clk,
    input  ispf_pkg::mac_ctl_t                  ctl,
    input  logic [ispf_pkg::SAMPLE_W-1:0]       sample,
    input  logic [ispf_pkg::GAIN_W-1:0]         gain,
    output logic [ispf_pkg::SAMPLE_W-1:0]       result
);

    localparam int AW = ispf_pkg::ACC_W;
    localparam logic signed [AW-1:0] HALF   = AW'(1) << (ispf_pkg::FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SAT_HI = AW'((1 << (ispf_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    logic signed [ispf_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]               acc_reg;
    logic signed [AW-1:0]               biased;
    logic signed [AW-1:0]               shifted;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= $signed(sample) * $signed({1'b0, gain});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // Round half up, floor shift back to Q1.15, clamp to the sample range
    always_comb
    begin
        biased  = acc_reg + HALF;
        shifted = biased >>> ispf_pkg::FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            result = SAT_HI[ispf_pkg::SAMPLE_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[ispf_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            result = shifted[ispf_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

### sv/input_shaper_sparse_fir_top.sv
// Input shaper, sparse FIR form: one request at a time, taken in turn through one
// delay-line read and one multiply per tap, and the next request is taken only once
// the result is delivered. Pass-through (tap_count zero) registers the sample as the
// result. rst_n (asynchronous, active low) clears the control and configuration
// registers, then a clearing pass zeroes the delay line; no request is taken
// during it, config writes are. Depends on ispf_pkg, ispf_delay_ram and ispf_mac.
module input_shaper_sparse_fir_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side: tdata = reference_sample[15:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ispf_pkg::SAMPLE_W-1:0]       s_tdata,
    // master side: tdata = shaped_sample[15:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ispf_pkg::SAMPLE_W-1:0]       m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ispf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ispf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = ispf_pkg::ADDR_W;
    localparam int TW = ispf_pkg::TIDX_W;

    // Configuration registers
    logic [ispf_pkg::TAPCNT_W-1:0] tap_count_reg;
    logic [ispf_pkg::GAIN_W-1:0]   gain_reg [ispf_pkg::MAX_TAPS];
    logic [ispf_pkg::LAG_W-1:0]    lag_reg  [ispf_pkg::MAX_TAPS];

    // Sequencer state
    ispf_pkg::state_t       state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg;
    logic [AW-1:0]          wpos_reg;
    logic [AW-1:0]          base_reg;
    logic [TW-1:0]          tap_idx_reg;
    logic [TW-1:0]          last_idx_reg;
    logic                   issue_reg;
    logic                   p1_reg;
    logic                   p2_reg;
    logic [ispf_pkg::GAIN_W-1:0]   gain_p1_reg;
    logic [ispf_pkg::SAMPLE_W-1:0] out_reg;

    logic                          s_fire;
    logic                          m_fire;
    logic                          pass_through;
    logic [ispf_pkg::TAPCNT_W-1:0] taps_eff;
    logic [ispf_pkg::LAG_W-1:0]    lag_sel;
    logic                          drained;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [ispf_pkg::SAMPLE_W-1:0] ram_wr_data;
    logic [AW-1:0]                 ram_rd_addr;
    logic [ispf_pkg::SAMPLE_W-1:0] ram_rd_data;

    ispf_pkg::mac_ctl_t            mac_ctl;
    logic [ispf_pkg::SAMPLE_W-1:0] mac_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ispf_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == ispf_pkg::ST_OUT);
    assign m_tdata   = out_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;

    // Clamp the tap count; zero means pass through
    assign pass_through = (tap_count_reg == '0);
    assign taps_eff = (tap_count_reg > ispf_pkg::TAPCNT_W'(ispf_pkg::MAX_TAPS))
                    ? ispf_pkg::TAPCNT_W'(ispf_pkg::MAX_TAPS) : tap_count_reg;

    // Tap zero always sits at the newest entry
    assign lag_sel = (tap_idx_reg == '0) ? '0 : lag_reg[tap_idx_reg];
    // Long lags wrap modulo the ring depth by truncation
    assign ram_rd_addr = base_reg - AW'(lag_sel);

    assign drained = !issue_reg && !p1_reg && !p2_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
            for (int i = 0; i < ispf_pkg::MAX_TAPS; i++)
            begin
                gain_reg[i] <= '0;
                lag_reg[i]  <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ispf_pkg::reg_idx_t'(cfg_index))
                ispf_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[ispf_pkg::TAPCNT_W-1:0];
                ispf_pkg::REG_GAIN_TAP0: gain_reg[0]   <= cfg_data[ispf_pkg::GAIN_W-1:0];
                ispf_pkg::REG_GAIN_TAP1: gain_reg[1]   <= cfg_data[ispf_pkg::GAIN_W-1:0];
                ispf_pkg::REG_GAIN_TAP2: gain_reg[2]   <= cfg_data[ispf_pkg::GAIN_W-1:0];
                ispf_pkg::REG_GAIN_TAP3: gain_reg[3]   <= cfg_data[ispf_pkg::GAIN_W-1:0];
                ispf_pkg::REG_LAG_TAP1:  lag_reg[1]    <= cfg_data[ispf_pkg::LAG_W-1:0];
                ispf_pkg::REG_LAG_TAP2:  lag_reg[2]    <= cfg_data[ispf_pkg::LAG_W-1:0];
                ispf_pkg::REG_LAG_TAP3:  lag_reg[3]    <= cfg_data[ispf_pkg::LAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state: clear the ring, wait for a request, walk the taps, hold the result
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ispf_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(ispf_pkg::DEPTH - 1))
                begin
                    state_next = ispf_pkg::ST_IDLE;
                end
            end
            ispf_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = pass_through ? ispf_pkg::ST_OUT : ispf_pkg::ST_RUN;
                end
            end
            ispf_pkg::ST_RUN:
            begin
                if (drained)
                begin
                    state_next = ispf_pkg::ST_OUT;
                end
            end
            ispf_pkg::ST_OUT:
            begin
                if (m_fire)
                begin
                    state_next = ispf_pkg::ST_IDLE;
                end
            end
            default: state_next = ispf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ispf_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            wpos_reg     <= '0;
            issue_reg    <= 1'b0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            tap_idx_reg  <= '0;
            last_idx_reg <= '0;
            base_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ispf_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            // Accept: write the sample at the current position, then advance it
            if (s_fire && !pass_through)
            begin
                base_reg     <= wpos_reg;
                wpos_reg     <= wpos_reg + AW'(1);
                tap_idx_reg  <= '0;
                last_idx_reg <= TW'(taps_eff - ispf_pkg::TAPCNT_W'(1));
                issue_reg    <= 1'b1;
            end
            else if (issue_reg)
            begin
                tap_idx_reg <= tap_idx_reg + TW'(1);
                if (tap_idx_reg == last_idx_reg)
                begin
                    issue_reg <= 1'b0;
                end
            end
            // Read data lands in p1, product in p2, accumulate after p2
            p1_reg <= issue_reg;
            p2_reg <= p1_reg;
        end
    end

    // Gain is registered alongside its read so that it meets the read data
    always_ff @(posedge clk)
    begin
        if (issue_reg)
        begin
            gain_p1_reg <= gain_reg[tap_idx_reg];
        end
    end

    // Output holding register
    always_ff @(posedge clk)
    begin
        if (s_fire && pass_through)
        begin
            out_reg <= s_tdata;
        end
        else if (state_reg == ispf_pkg::ST_RUN && drained)
        begin
            out_reg <= mac_result;
        end
    end

    // Ring writes: zero during the clearing pass, the new sample on a non-pass-through accept
    always_comb
    begin
        if (state_reg == ispf_pkg::ST_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = s_fire && !pass_through;
            ram_wr_addr = wpos_reg;
            ram_wr_data = s_tdata;
        end
    end

    assign mac_ctl.acc_clear = s_fire;
    assign mac_ctl.mul_en    = p1_reg;
    assign mac_ctl.acc_en    = p2_reg;

    ispf_delay_ram u_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ispf_mac u_mac
    (
        .clk    (clk),
        .ctl    (mac_ctl),
        .sample (ram_rd_data),
        .gain   (gain_p1_reg),
        .result (mac_result)
    );

endmodule

### sv/ispf_checker.sv
// Port-level checks for the input shaper top level, attached by bind.
// Depends on ispf_pkg for port widths.
module ispf_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ispf_pkg::SAMPLE_W-1:0]       m_tdata
);

    // One request in flight: no intake while a result is held
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("intake open while a result is held");

    // After an accepted request the intake closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("intake stayed open after a request");

    // A delivered result is not repeated
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result offered twice");

    // Stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind input_shaper_sparse_fir_top ispf_checker u_ispf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/ispf_tb_pkg.sv
// Scoreboard for the sparse FIR input shaper bench: shadow registers, delay-line
// predictor and the queue of expected shaped samples.
// Depends on ispf_pkg.
package ispf_tb_pkg;

    import ispf_pkg::*;

    class shaper_scoreboard;

        logic [TAPCNT_W-1:0]        tap_count;
        logic [GAIN_W-1:0]          gain [MAX_TAPS];
        // lag[0] is never written: tap 0 always reads the newest entry
        logic [LAG_W-1:0]           lag [MAX_TAPS];
        logic signed [SAMPLE_W-1:0] history [DEPTH];
        logic [ADDR_W-1:0]          head;
        logic signed [SAMPLE_W-1:0] shaped_q [$];
        int                         errors;

        function new();
            tap_count = '0;
            head      = '0;
            errors    = 0;
            foreach (gain[t])
            begin
                gain[t] = '0;
                lag[t]  = '0;
            end
            foreach (history[i])
                history[i] = '0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TAP_COUNT: tap_count = data[TAPCNT_W-1:0];
                REG_GAIN_TAP0: gain[0]   = data[GAIN_W-1:0];
                REG_GAIN_TAP1: gain[1]   = data[GAIN_W-1:0];
                REG_GAIN_TAP2: gain[2]   = data[GAIN_W-1:0];
                REG_GAIN_TAP3: gain[3]   = data[GAIN_W-1:0];
                REG_LAG_TAP1:  lag[1]    = data[LAG_W-1:0];
                REG_LAG_TAP2:  lag[2]    = data[LAG_W-1:0];
                REG_LAG_TAP3:  lag[3]    = data[LAG_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] shape(logic signed [SAMPLE_W-1:0] sample);
            int unsigned       taps;
            longint            acc;
            longint            rounded;
            longint            hi;
            logic [ADDR_W-1:0] idx;
            // pass-through leaves the line and the write position alone
            if (tap_count == 0)
                return sample;
            taps = (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
            history[head] = sample;
            acc = 0;
            for (int t = 0; t < taps; t++)
            begin
                idx = head - lag[t];
                acc += longint'(history[idx]) * longint'(gain[t]);
            end
            // add half an LSB then floor, so ties go towards plus infinity
            rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
            if (rounded > hi)
                rounded = hi;
            if (rounded < -hi - 1)
                rounded = -hi - 1;
            head = head + 1'b1;
            return SAMPLE_W'(rounded);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            shaped_q.push_back(shape(signed'(raw)));
        endfunction

        function void check_shaped(logic [SAMPLE_W-1:0] raw);
            logic signed [SAMPLE_W-1:0] want;
            if (shaped_q.size() == 0)
            begin
                $error("shaped_sample: result with no request waiting, actual %0d",
                       signed'(raw));
                errors++;
                return;
            end
            want = shaped_q.pop_front();
            if (signed'(raw) !== want)
            begin
                $error("shaped_sample mismatch: expected %0d, actual %0d", want, signed'(raw));
                errors++;
            end
        endfunction

        function int pending();
            return shaped_q.size();
        endfunction

    endclass

endpackage

### dv/tb_top.sv
// Bench top for input_shaper_sparse_fir_top: drives sample requests and register
// writes, stalls the result side, and checks every shaped sample.
// Depends on ispf_pkg, ispf_tb_pkg and the block's RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ispf_pkg::*;
    import ispf_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int RANDOM_PHASES   = 8;
    // room for the longest request to finish; leave a margin on top
    localparam int DRAIN_CYCLES    = MAX_TAPS + 12;
    localparam int HOLD_OFF_CYCLES = 300;
    // clearing pass plus the slowest run, several times over
    localparam int LIMIT_NS        = 5_000_000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;   // [15:0] reference_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] shaped_sample
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // receiver behaviour, written by the main sequence only
    int stall_pct         = 0;
    int hold_off_requests = 0;

    shaper_scoreboard sb = new();

    input_shaper_sparse_fir_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung block
    initial
    begin
        #(LIMIT_NS);
        $display("** input_shaper_sparse_fir_top: FAILED **");
        $finish;
    end

    // Both handshakes are sampled at the edge, before any of this step's updates land.
    // Note each accepted request for prediction, check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_shaped(m_tdata);
    end

    // Result side: random stalls, plus long hold-offs counted here on request
    // from the main sequence so that the block fills up and backs off its input.
    initial
    begin
        int hold_off_served;
        int hold_left;
        hold_off_served = 0;
        hold_left       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_served != hold_off_requests)
            begin
                hold_off_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Write one register and mirror it into the predictor once accepted
    task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample request after a random idle gap; hold it until taken.
    // tvalid stays high straight into the next request when there is no gap.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    // Stop offering, let every expected result arrive, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                    sender_idle;
        int                    mode;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   sample;

        sender_idle = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through with reset registers: extremes come back unchanged.
        // These requests wait out the clearing pass.
        send_sample(16'h8000, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h0000, 0);
        send_sample(16'hFFFF, 0);
        send_sample(16'h0001, 0);
        drain_results();

        // Tap count above the maximum, every gain at its top, tap 1 on the newest
        // entry and tap 3 at the longest lag: drives both saturation rails
        write_register(REG_TAP_COUNT, 16'd7);
        write_register(REG_GAIN_TAP0, 16'hFFFF);
        write_register(REG_GAIN_TAP1, 16'hFFFF);
        write_register(REG_GAIN_TAP2, 16'hFFFF);
        write_register(REG_GAIN_TAP3, 16'hFFFF);
        write_register(REG_LAG_TAP1, 16'd0);
        write_register(REG_LAG_TAP2, 16'd1);
        write_register(REG_LAG_TAP3, 16'd1023);
        send_sample(16'h7FFF, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h0000, 0);
        send_sample(16'h0001, 0);
        drain_results();

        // One tap at half gain: odd samples land exactly on rounding ties
        write_register(REG_TAP_COUNT, 16'd1);
        write_register(REG_GAIN_TAP0, 16'd16384);
        send_sample(16'h0001, 0);
        send_sample(16'hFFFF, 0);
        send_sample(16'h0003, 0);
        send_sample(16'hFFFD, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        drain_results();

        // All four taps at unity; lag data with upper bits set must be cut to width
        write_register(REG_TAP_COUNT, 16'd4);
        write_register(REG_GAIN_TAP0, 16'd32768);
        write_register(REG_GAIN_TAP1, 16'd32768);
        write_register(REG_GAIN_TAP2, 16'd32768);
        write_register(REG_GAIN_TAP3, 16'd32768);
        write_register(REG_LAG_TAP1, 16'hFFFF);
        write_register(REG_LAG_TAP2, 16'd2);
        write_register(REG_LAG_TAP3, 16'h0401);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'd12345, 0);
        send_sample(16'hFFFF, 0);
        drain_results();

        // Random phases: fresh settings each time, idling pattern rotates
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = phase % 4;
            case (mode)
                0:       begin sender_idle = 0;  stall_pct = 0;  end
                1:       begin sender_idle = 75; stall_pct = 0;  end
                2:       begin sender_idle = 0;  stall_pct = 75; end
                default: begin sender_idle = 34; stall_pct = 34; end
            endcase

            // Pin a few phases to the extremes: full taps, clamp to four, pass-through
            case (phase)
                0:       data = 16'd4;
                3:       data = 16'd7;
                6:       data = 16'd0;
                default: data = 16'($urandom_range(7));
            endcase
            write_register(REG_TAP_COUNT, data);

            for (int t = 0; t < MAX_TAPS; t++)
            begin
                case ($urandom_range(3))
                    0:       data = 16'($urandom_range(32768));
                    1:       data = 16'd32768;
                    2:       data = 16'($urandom);
                    default: data = 16'($urandom_range(8192));
                endcase
                if (phase == 3)
                    data = 16'hFFFF;
                if (phase == 5)
                    data = '0;
                write_register(reg_idx_t'(REG_GAIN_TAP0 + t), data);
            end

            for (int t = 1; t < MAX_TAPS; t++)
            begin
                case ($urandom_range(3))
                    0:       data = 16'($urandom_range(7));
                    1:       data = 16'd1023;
                    default: data = 16'($urandom_range(1023));
                endcase
                // junk above the lag width now and then
                if ($urandom_range(3) == 0)
                    data[CFG_DATA_W-1:LAG_W] = (CFG_DATA_W-LAG_W)'($urandom_range(63) + 1);
                write_register(reg_idx_t'(REG_LAG_TAP1 + t - 1), data);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Hold the result side off while requests keep coming
                if (mode == 0 && n == ITEMS_PER_PHASE / 3)
                    hold_off_requests++;
                // Pause mid-phase until every result is back
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                case ($urandom_range(7))
                    0:       sample = 16'h8000;
                    1:       sample = 16'h7FFF;
                    2:       sample = 16'($urandom_range(64)) - 16'd32;
                    default: sample = 16'($urandom);
                endcase
                send_sample(sample, sender_idle);
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** input_shaper_sparse_fir_top: PASSED **");
        else
            $display("** input_shaper_sparse_fir_top: FAILED **");
        $finish;
    end

endmodule
